@@ design/abf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_pkg
// Shared types and constants of the ATA block address formatter.
// ----------------------------------------------------------------------------
package abf_pkg;

	localparam int BLK_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int HEADS_W    = 5;
	localparam int SPT_W      = 6;
	localparam int PER_CYL_W  = HEADS_W + SPT_W;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV1_STEPS = 16;
	localparam int DIV2_STEPS = 6;
	localparam int STEP_W     = $clog2(DIV1_STEPS);

	localparam logic [BYTE_W-1:0] LBA_FLAG = 8'h40;

	localparam logic [1:0] REG_LBA_MODE = 2'd0;
	localparam logic [1:0] REG_HEADS    = 2'd1;
	localparam logic [1:0] REG_SPT      = 2'd2;

	localparam logic               RST_LBA_MODE = 1'b1;
	localparam logic [HEADS_W-1:0] RST_HEADS    = 5'd16;
	localparam logic [SPT_W-1:0]   RST_SPT      = 6'd63;

	typedef struct packed {
		logic               lba_mode;
		logic [HEADS_W-1:0] heads;
		logic [SPT_W-1:0]   spt;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_LBA  = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_GEOM = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [PER_CYL_W-1:0] per_cyl;
		logic [SPT_W-1:0]     spt;
		logic [BLK_W-1:0]     blk;
		logic [BYTE_W-1:0]    base;
	} job_t;

	typedef struct packed {
		logic              out_of_range;
		logic [BYTE_W-1:0] drive_head;
		logic [BYTE_W-1:0] cylinder_high;
		logic [BYTE_W-1:0] cylinder_low;
		logic [BYTE_W-1:0] sector_number;
	} result_t;

endpackage

@@ design/abf_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_regs
// Configuration registers behind the APB port.
// ----------------------------------------------------------------------------
module abf_regs import abf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lba_mode <= RST_LBA_MODE;
			cfg_q.heads    <= RST_HEADS;
			cfg_q.spt      <= RST_SPT;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_LBA_MODE: cfg_q.lba_mode <= pwdata[0];
				REG_HEADS:    cfg_q.heads    <= pwdata[HEADS_W-1:0];
				REG_SPT:      cfg_q.spt      <= pwdata[SPT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_LBA_MODE: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.lba_mode};
			REG_HEADS:    prdata = {{(PDATA_W-HEADS_W){1'b0}}, cfg_q.heads};
			REG_SPT:      prdata = {{(PDATA_W-SPT_W){1'b0}}, cfg_q.spt};
			default:      prdata = '0;
		endcase
	end

endmodule

@@ design/abf_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_front
// Accepts input transactions, classifies them and forms the divisor.
// ----------------------------------------------------------------------------
module abf_front import abf_pkg::*; (
	input  cfg_t              cfg,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BLK_W-1:0]  blk,
	input  logic [BYTE_W-1:0] base,
	input  logic              push_ready,
	output logic              push,
	output job_t              push_job
);

	assign s_tready = push_ready;
	assign push     = s_tvalid & push_ready;

	always_comb begin
		push_job.blk     = blk;
		push_job.base    = base;
		push_job.spt     = cfg.spt;
		push_job.per_cyl = {{SPT_W{1'b0}}, cfg.heads} * {{HEADS_W{1'b0}}, cfg.spt};
		if (cfg.lba_mode) begin
			push_job.kind = KIND_LBA;
		end else if (cfg.heads == '0 || cfg.spt == '0) begin
			push_job.kind = KIND_ZERO;
		end else begin
			push_job.kind = KIND_GEOM;
		end
	end

endmodule

@@ design/abf_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module abf_queue import abf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic push_ready,
	input  logic pop,
	output logic pop_valid,
	output job_t pop_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow push");
`endif

endmodule

@@ design/abf_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abf_back
// Carries out jobs: LBA slicing, an out-of-range result for zero geometry,
// or two iterative divisions for geometry.
module abf_back import abf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  job_t    in_job,
	output logic    pop,
	output logic    m_tvalid,
	input  logic    m_tready,
	output result_t m_res
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV1 = 4'b0010,
		ST_DIV2 = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	logic [STEP_W-1:0]    step_q;
	logic [BLK_W-1:0]     dvd_q;
	logic [BLK_W-1:0]     quo_q;
	logic [PER_CYL_W-1:0] rem_q;
	logic [PER_CYL_W-1:0] dvs_q;
	logic [SPT_W-1:0]     spt_q;
	logic [BYTE_W-1:0]    base_q;
	logic [15:0]          cyl_q;
	logic                 cyl_big_q;
	logic [3:0]           head_q;
	logic                 head_big_q;
	logic [BYTE_W-1:0]    sec_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic                 slot_free;
	logic                 last1;
	logic                 last2;
	logic [PER_CYL_W-1:0] rem_nx;
	logic [1:0]           qbits;
	logic [PER_CYL_W:0]   trial;
	logic                 load_res;
	result_t              res_d;

	assign slot_free = !res_valid_q || m_tready;
	assign pop       = in_valid && (state_q == ST_IDLE) && slot_free;
	assign last1     = (step_q == STEP_W'(DIV1_STEPS - 1));
	assign last2     = (step_q == STEP_W'(DIV2_STEPS - 1));
	assign m_tvalid  = res_valid_q;
	assign m_res     = res_q;

	// two restoring steps per cycle
	always_comb begin
		rem_nx = rem_q;
		qbits  = '0;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_nx, dvd_q[BLK_W-1-i]};
			if (trial >= {1'b0, dvs_q}) begin
				trial        = trial - {1'b0, dvs_q};
				qbits[1-i]   = 1'b1;
			end
			rem_nx = trial[PER_CYL_W-1:0];
		end
	end

	always_comb begin
		load_res = 1'b0;
		res_d    = '0;
		if (pop && in_job.kind == KIND_LBA) begin
			load_res            = 1'b1;
			res_d.sector_number = in_job.blk[7:0];
			res_d.cylinder_low  = in_job.blk[15:8];
			res_d.cylinder_high = in_job.blk[23:16];
			res_d.drive_head    = in_job.base | LBA_FLAG | {4'b0, in_job.blk[27:24]};
			res_d.out_of_range  = (in_job.blk[31:28] != '0);
		end else if (pop && in_job.kind == KIND_ZERO) begin
			load_res           = 1'b1;
			res_d.drive_head   = in_job.base;
			res_d.out_of_range = 1'b1;
		end else if (state_q == ST_DONE && slot_free) begin
			load_res            = 1'b1;
			res_d.sector_number = sec_q;
			res_d.cylinder_low  = cyl_q[7:0];
			res_d.cylinder_high = cyl_q[15:8];
			res_d.drive_head    = base_q | {4'b0, head_q};
			res_d.out_of_range  = cyl_big_q | head_big_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (m_tready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop && in_job.kind != KIND_LBA && in_job.kind != KIND_ZERO) begin
						state_q <= ST_DIV1;
						step_q  <= '0;
					end
				end
				ST_DIV1: begin
					step_q <= last1 ? '0 : step_q + 1'b1;
					if (last1) begin
						state_q <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					step_q <= step_q + 1'b1;
					if (last2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
		if (state_q == ST_IDLE) begin
			dvd_q  <= in_job.blk;
			dvs_q  <= in_job.per_cyl;
			spt_q  <= in_job.spt;
			base_q <= in_job.base;
			rem_q  <= '0;
			quo_q  <= '0;
		end else if (state_q == ST_DIV1) begin
			if (last1) begin
				cyl_q     <= {quo_q[13:0], qbits};
				cyl_big_q <= (quo_q[29:14] != '0);
				dvd_q     <= {1'b0, rem_nx, {(BLK_W-1-PER_CYL_W){1'b0}}};
				dvs_q     <= {{(PER_CYL_W-SPT_W){1'b0}}, spt_q};
				rem_q     <= '0;
				quo_q     <= '0;
			end else begin
				dvd_q <= {dvd_q[BLK_W-3:0], 2'b00};
				rem_q <= rem_nx;
				quo_q <= {quo_q[BLK_W-3:0], qbits};
			end
		end else if (state_q == ST_DIV2) begin
			dvd_q <= {dvd_q[BLK_W-3:0], 2'b00};
			rem_q <= rem_nx;
			quo_q <= {quo_q[BLK_W-3:0], qbits};
			if (last2) begin
				head_q     <= {quo_q[1:0], qbits};
				head_big_q <= (quo_q[9:2] != '0);
				sec_q      <= {{(BYTE_W-SPT_W){1'b0}}, rem_nx[SPT_W-1:0]} + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_rem_below_dvs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 || state_q == ST_DIV2) |-> rem_q < dvs_q)
		else $error("partial remainder not below divisor");

	a_div1_to_div2: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV1 && last1 |=> state_q == ST_DIV2 && step_q == '0)
		else $error("first division did not hand over to second");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && slot_free |=> res_valid_q && state_q == ST_IDLE)
		else $error("finished geometry job not delivered");
`endif

endmodule

@@ design/ata_block_address_formatter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_block_address_formatter
// Turns a block number and a base drive/head byte into the four ATA
// task-file address bytes plus an out-of-range flag. In LBA mode the
// block number is sliced into bytes and the back delivers one transaction
// per cycle while the output is not stalled. In geometry mode the back
// loads the job, divides block number by heads*sectors and then the
// remainder by sectors, two quotient bits a cycle in one shared restoring
// divider, and then hands the result over; with zero heads or sectors it
// flags out of range without dividing. A two-entry queue between the input
// side and the divider keeps accepting input while a result waits on the output.
// ----------------------------------------------------------------------------
module ata_block_address_formatter import abf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [39:0]        s_tdata,  // block_number, drive_head_base
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [39:0]        m_tdata   // sector_number, cylinder_low, cylinder_high,
	                                     // drive_head, out_of_range, zero pad
);

	cfg_t    cfg;
	logic    push;
	logic    push_ready;
	job_t    push_job;
	logic    pop;
	logic    pop_valid;
	job_t    pop_job;
	result_t res;

	abf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	abf_front u_front (
		.cfg        (cfg),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.blk        (s_tdata[31:0]),
		.base       (s_tdata[39:32]),
		.push_ready (push_ready),
		.push       (push),
		.push_job   (push_job)
	);

	abf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job)
	);

	abf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop_valid),
		.in_job   (pop_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_res    (res)
	);

	assign m_tdata = {7'b0, res};

endmodule
